// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the page frame allocator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

// ----- src/pfa_pkg.sv -----
// ----------------------------------------------------------------------------
// pfa_pkg
// Types and constants of the page frame allocate-and-map block.
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int DIR_SEL_W   = 2;
  localparam int VPAGE_W     = 10;
  localparam int FRAME_OUT_W = 10;
  localparam int FREE_OUT_W  = 6;
  localparam int ENTRY_W     = 14;
  localparam int DIR_ENTRIES = 1024;

  // Directory entry layout: flags in the low nibble, frame above.
  localparam int E_PRESENT_BIT = 0;
  localparam int E_FRAME_LSB   = 4;

  localparam logic [VPAGE_W-1:0] KERNEL_SLOT = 10'h300;
  // Present, writable, 4 MB, frame 0.
  localparam logic [ENTRY_W-1:0] BOOT_ENTRY = 14'h00B;
  // Present, writable, user, 4 MB.
  localparam logic [3:0] USER_FLAGS = 4'hF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

endpackage

// ----- src/pfa_req_if.sv -----
// ----------------------------------------------------------------------------
// pfa_req_if
// Request channel: one allocate or free command per word.
// ----------------------------------------------------------------------------
interface pfa_req_if;
  logic                           valid;
  logic                           ready;
  logic                           cmd;
  logic [pfa_pkg::DIR_SEL_W-1:0]  dir_select;
  logic [pfa_pkg::VPAGE_W-1:0]    virt_page;

  modport source (output valid, output cmd, output dir_select, output virt_page,
                  input ready);
  modport sink   (input valid, input cmd, input dir_select, input virt_page,
                  output ready);
endinterface

// ----- src/pfa_rsp_if.sv -----
// ----------------------------------------------------------------------------
// pfa_rsp_if
// Response channel: status, frame and free count per word.
// ----------------------------------------------------------------------------
interface pfa_rsp_if;
  logic                            valid;
  logic                            ready;
  logic                            ok;
  logic [pfa_pkg::FRAME_OUT_W-1:0] frame_index;
  logic [pfa_pkg::FREE_OUT_W-1:0]  frames_free;

  modport source (output valid, output ok, output frame_index, output frames_free,
                  input ready);
  modport sink   (input valid, input ok, input frame_index, input frames_free,
                  output ready);
endinterface

// ----- src/pfa_ram.sv -----
// ----------------------------------------------------------------------------
// pfa_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pfa_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/page_frame_allocate_and_map.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocate_and_map
// First-fit 4 MB frame allocator with page directories held in a RAM.
// ----------------------------------------------------------------------------
// Requests arrive on req_i: cmd selects allocate-and-map or free, dir_select
// and virt_page name one directory entry. Each request returns exactly one
// response word on rsp_o with ok, the frame and the free count after it.
// The directory entry of a request is read from the RAM in the accept cycle;
// the result is computed, written back and registered in the execute state
// that follows. A new request is taken only after the last one has left the
// execute state; the read-modify-write of the directory RAM sets this.
// The lowest free frame comes from a priority encoder over the frame bitmap.
// After reset the block clears the directory RAM, one entry per cycle over
// NUM_DIRS (at most 4) times 1024 entries, with req_i.ready low; it presets
// the kernel entries and entry 0 of directory 0 to frame 0, zeroes the rest.
// The response register lets one more request be accepted while a response
// waits. When rsp_o is stalled, that request stays in its execute cycle
// and commits nothing until the response register frees.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module page_frame_allocate_and_map #(
  parameter int FRAME_COUNT = 32,
  parameter int NUM_DIRS    = 4
) (
  input logic        clk_i,
  input logic        rst_ni,
  pfa_req_if.sink    req_i,
  pfa_rsp_if.source  rsp_o
);

  localparam int MaxDirs  = 1 << pfa_pkg::DIR_SEL_W;
  localparam int DirsUsed = (NUM_DIRS < MaxDirs) ? NUM_DIRS : MaxDirs;
  localparam int DirSlots = DirsUsed * pfa_pkg::DIR_ENTRIES;
  localparam int AddrW    = $clog2(DirSlots);
  localparam int FrameW   = $clog2(FRAME_COUNT);
  localparam int CntW     = $clog2(FRAME_COUNT + 1);
  localparam int SlotW    = pfa_pkg::DIR_SEL_W + pfa_pkg::VPAGE_W;
  localparam int FrmCmpW  = pfa_pkg::FRAME_OUT_W + 1;

  pfa_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]       clr_addr_q, clr_addr_d;
  logic [FRAME_COUNT-1:0] used_q, used_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;

  logic                          cmd_q;
  logic [pfa_pkg::DIR_SEL_W-1:0] dir_q;
  logic [pfa_pkg::VPAGE_W-1:0]   vp_q;

  logic                            out_ok_q;
  logic [pfa_pkg::FRAME_OUT_W-1:0] out_frame_q;
  logic [pfa_pkg::FREE_OUT_W-1:0]  out_free_q;

  logic                        accept;
  logic                        can_load;
  logic [SlotW-1:0]            req_slot;
  logic [SlotW-1:0]            held_slot;
  logic                        req_dir_ok;
  logic                        dir_ok;

  logic                        ram_we;
  logic [AddrW-1:0]            ram_waddr;
  logic [pfa_pkg::ENTRY_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [pfa_pkg::ENTRY_W-1:0] ram_rdata;

  logic                            alloc_found;
  logic [FrameW-1:0]               alloc_idx;
  logic [pfa_pkg::FRAME_OUT_W-1:0] ent_frame;
  logic                            ent_present;
  logic                            ent_in_map;
  logic [FrameW-1:0]               ent_idx;
  logic [pfa_pkg::VPAGE_W-1:0]     clr_vp;

  logic                            res_ok;
  logic [pfa_pkg::FRAME_OUT_W-1:0] res_frame;
  logic [FrmCmpW-1:0]              cnt_ext;

  assign accept    = req_i.valid && req_i.ready;
  assign can_load  = !out_valid_q || rsp_o.ready;
  assign req_slot  = {req_i.dir_select, req_i.virt_page};
  assign held_slot = {dir_q, vp_q};
  assign req_dir_ok = 6'(req_i.dir_select) < 6'(NUM_DIRS);
  assign dir_ok     = 6'(dir_q) < 6'(NUM_DIRS);

  assign ram_re = accept && req_dir_ok;

  // Entry fields of the word read in the accept cycle.
  assign ent_present = ram_rdata[pfa_pkg::E_PRESENT_BIT];
  assign ent_frame   = ram_rdata[pfa_pkg::ENTRY_W-1:pfa_pkg::E_FRAME_LSB];
  assign ent_in_map  = {1'b0, ent_frame} < FrmCmpW'(FRAME_COUNT);
  assign ent_idx     = ent_frame[FrameW-1:0];
  assign clr_vp      = clr_addr_q[pfa_pkg::VPAGE_W-1:0];

  // Lowest free frame.
  always_comb begin
    alloc_found = 1'b0;
    alloc_idx   = '0;
    for (int i = FRAME_COUNT - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        alloc_found = 1'b1;
        alloc_idx   = FrameW'(i);
      end
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pfa_pkg::ST_CLEAR: begin
        if (clr_addr_q == AddrW'(DirSlots - 1)) begin
          state_d = pfa_pkg::ST_IDLE;
        end
      end
      pfa_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = pfa_pkg::ST_EXEC;
        end
      end
      pfa_pkg::ST_EXEC: begin
        if (can_load) begin
          state_d = pfa_pkg::ST_IDLE;
        end
      end
      default: state_d = pfa_pkg::ST_CLEAR;
    endcase
  end

  // Outputs and datapath updates.
  always_comb begin
    req_i.ready = 1'b0;
    clr_addr_d  = clr_addr_q;
    used_d      = used_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = held_slot[AddrW-1:0];
    ram_wdata   = '0;
    res_ok      = 1'b0;
    res_frame   = '0;
    case (state_q)
      pfa_pkg::ST_CLEAR: begin
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        clr_addr_d = clr_addr_q + AddrW'(1);
        if (clr_vp == pfa_pkg::KERNEL_SLOT || clr_addr_q == '0) begin
          ram_wdata = pfa_pkg::BOOT_ENTRY;
        end
      end
      pfa_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
      end
      pfa_pkg::ST_EXEC: begin
        if (can_load) begin
          out_valid_d = 1'b1;
          if (dir_ok) begin
            if (cmd_q == pfa_pkg::CMD_ALLOC) begin
              if (alloc_found) begin
                used_d[alloc_idx] = 1'b1;
                cnt_d     = cnt_q - CntW'(1);
                ram_we    = 1'b1;
                ram_wdata = {pfa_pkg::FRAME_OUT_W'(alloc_idx), pfa_pkg::USER_FLAGS};
                res_ok    = 1'b1;
                res_frame = pfa_pkg::FRAME_OUT_W'(alloc_idx);
              end
            end else if (ent_present && ent_in_map) begin
              // A frame that is already free keeps the count as it is.
              if (used_q[ent_idx]) begin
                used_d[ent_idx] = 1'b0;
                cnt_d = cnt_q + CntW'(1);
              end
              ram_we    = 1'b1;
              ram_wdata = '0;
              res_ok    = 1'b1;
              res_frame = ent_frame;
            end
          end
        end
      end
      default: ;
    endcase
  end

  assign cnt_ext = FrmCmpW'(cnt_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfa_pkg::ST_CLEAR;
      clr_addr_q  <= '0;
      used_q      <= {{(FRAME_COUNT - 1){1'b0}}, 1'b1};
      cnt_q       <= CntW'(FRAME_COUNT - 1);
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      used_q      <= used_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i.cmd;
      dir_q <= req_i.dir_select;
      vp_q  <= req_i.virt_page;
    end
    if (state_q == pfa_pkg::ST_EXEC && can_load) begin
      out_ok_q    <= res_ok;
      out_frame_q <= res_frame;
      out_free_q  <= cnt_ext[pfa_pkg::FREE_OUT_W-1:0];
    end
  end

  pfa_ram #(
    .WIDTH (pfa_pkg::ENTRY_W),
    .DEPTH (DirSlots)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (req_slot[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.ok          = out_ok_q;
  assign rsp_o.frame_index = out_frame_q;
  assign rsp_o.frames_free = out_free_q;

  // The count always equals the number of clear bits in the map.
  `ASSERT_ALWAYS(a_count_tracks_map, clk_i, rst_ni,
                 int'(cnt_q) + $countones(used_q) == FRAME_COUNT)
  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, cnt_q <= CntW'(FRAME_COUNT))
  `ASSERT_IMPLY(a_no_accept_in_clear, clk_i, rst_ni,
                state_q == pfa_pkg::ST_CLEAR, !req_i.ready)
  `ASSERT_IMPLY(a_rsp_from_exec, clk_i, rst_ni,
                $rose(out_valid_q), $past(state_q) == pfa_pkg::ST_EXEC)

endmodule

// ----- dv/page_frame_allocate_and_map_tb.sv -----
// ----------------------------------------------------------------------------
// page_frame_allocate_and_map_tb
// Self-checking bench for the first-fit page frame allocator.
// ----------------------------------------------------------------------------
// A table of directed requests covers the preset kernel entries, refused
// frees, freeing a frame that is already free and overwriting a mapped
// entry. Random requests follow. Most allocations target empty entries and
// most frees target entries that were mapped earlier, so the frame pool
// drains and refills several times. Each response is checked against a typed
// result or a predictor with its own frame bitmap, free count and directories.
// ----------------------------------------------------------------------------
module page_frame_allocate_and_map_tb;

  localparam int FRAME_COUNT   = 32;
  localparam int NUM_DIRS      = 4;
  localparam int ENTRY_FRAME_W = pfa_pkg::ENTRY_W - pfa_pkg::E_FRAME_LSB;
  localparam int STEP_N        = 20;
  localparam int CHUNK_N       = 7;
  localparam int CHUNK_ITEMS   = 100;
  // The limit also covers the clearing pass after reset, in which no word moves.
  localparam int IDLE_LIMIT    = 20000;

  typedef struct packed {
    logic                            ok;
    logic [pfa_pkg::FRAME_OUT_W-1:0] frame;
    logic [pfa_pkg::FREE_OUT_W-1:0]  free_cnt;
  } result_t;

  typedef struct packed {
    logic [pfa_pkg::DIR_SEL_W-1:0] dir;
    logic [pfa_pkg::VPAGE_W-1:0]   vpage;
  } slot_t;

  typedef struct {
    logic        cmd;
    int unsigned dir;
    int unsigned vpage;
    bit          typed;
    result_t     want;
  } step_t;

  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_e;

  localparam logic [pfa_pkg::VPAGE_W-1:0] HOT_PAGES [8] = '{
    10'h000, 10'h001, 10'h002, 10'h155, 10'h2AA, pfa_pkg::KERNEL_SLOT, 10'h3FE, 10'h3FF
  };

  // Directed requests. Expected results are typed in for the first requests
  // after reset and for refused frees; the rest are checked by the predictor.
  step_t steps [STEP_N] = '{
    '{pfa_pkg::CMD_FREE,  1, 5,           1'b1, '{1'b0, 10'd0, 6'd31}},
    '{pfa_pkg::CMD_ALLOC, 1, 5,           1'b1, '{1'b1, 10'd1, 6'd30}},
    '{pfa_pkg::CMD_ALLOC, 3, 1023,        1'b1, '{1'b1, 10'd2, 6'd29}},
    '{pfa_pkg::CMD_FREE,  1, 5,           1'b0, '0},
    '{pfa_pkg::CMD_ALLOC, 2, 0,           1'b0, '0},
    '{pfa_pkg::CMD_FREE,  0, 0,           1'b0, '0},
    '{pfa_pkg::CMD_FREE,  0, 0,           1'b1, '{1'b0, 10'd0, 6'd30}},
    '{pfa_pkg::CMD_FREE,  2, pfa_pkg::KERNEL_SLOT, 1'b0, '0},
    '{pfa_pkg::CMD_ALLOC, 0, pfa_pkg::KERNEL_SLOT, 1'b0, '0},
    '{pfa_pkg::CMD_ALLOC, 0, pfa_pkg::KERNEL_SLOT, 1'b0, '0},
    '{pfa_pkg::CMD_FREE,  0, pfa_pkg::KERNEL_SLOT, 1'b0, '0},
    '{pfa_pkg::CMD_FREE,  3, 1023,        1'b0, '0},
    '{pfa_pkg::CMD_FREE,  3, 1023,        1'b1, '{1'b0, 10'd0, 6'd30}},
    '{pfa_pkg::CMD_ALLOC, 3, 10'h2AA,     1'b0, '0},
    '{pfa_pkg::CMD_ALLOC, 0, 10'h155,     1'b0, '0},
    '{pfa_pkg::CMD_FREE,  3, 10'h2AA,     1'b0, '0},
    '{pfa_pkg::CMD_FREE,  0, 10'h155,     1'b0, '0},
    '{pfa_pkg::CMD_FREE,  1, pfa_pkg::KERNEL_SLOT, 1'b0, '0},
    '{pfa_pkg::CMD_ALLOC, 1, 1023,        1'b0, '0},
    '{pfa_pkg::CMD_FREE,  2, 0,           1'b0, '0}
  };

  int unsigned alloc_pct [CHUNK_N] = '{90, 30, 60, 90, 20, 55, 75};

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                          req_valid = 1'b0;
  logic                          req_cmd   = pfa_pkg::CMD_ALLOC;
  logic [pfa_pkg::DIR_SEL_W-1:0] req_dir   = '0;
  logic [pfa_pkg::VPAGE_W-1:0]   req_vpage = '0;
  logic                          rsp_ready = 1'b0;
  rx_mode_e                      rx_mode   = RX_RANDOM;
  int unsigned                   rx_tick   = 0;

  pfa_req_if req_if ();
  pfa_rsp_if rsp_if ();

  assign req_if.valid      = req_valid;
  assign req_if.cmd        = req_cmd;
  assign req_if.dir_select = req_dir;
  assign req_if.virt_page  = req_vpage;
  assign rsp_if.ready      = rsp_ready;

  page_frame_allocate_and_map #(
    .FRAME_COUNT(FRAME_COUNT),
    .NUM_DIRS   (NUM_DIRS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Predicted allocator state.
  logic [FRAME_COUNT-1:0]      frame_busy;
  int unsigned                 frames_left;
  logic [pfa_pkg::ENTRY_W-1:0] dir_table [NUM_DIRS][pfa_pkg::DIR_ENTRIES];

  result_t pending_results [$];
  slot_t   mapped_slots [$];

  int unsigned mismatch_count = 0;
  int unsigned checked_words  = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  bit          sender_steady  = 1'b0;
  int unsigned alloc_granted  = 0;
  int unsigned alloc_refused  = 0;
  int unsigned free_granted   = 0;
  int unsigned free_refused   = 0;

  function automatic void reset_allocator();
    frame_busy    = '0;
    frame_busy[0] = 1'b1;
    frames_left   = FRAME_COUNT - 1;
    foreach (dir_table[d, e]) dir_table[d][e] = '0;
    for (int d = 0; d < NUM_DIRS; d++) begin
      dir_table[d][pfa_pkg::KERNEL_SLOT] = pfa_pkg::BOOT_ENTRY;
    end
    dir_table[0][0] = pfa_pkg::BOOT_ENTRY;
  endfunction

  // Applies one request to the predicted state and returns its response.
  function automatic result_t apply_request(input logic cmd,
                                            input logic [pfa_pkg::DIR_SEL_W-1:0] dir,
                                            input logic [pfa_pkg::VPAGE_W-1:0] vpage);
    result_t                     res;
    logic [pfa_pkg::ENTRY_W-1:0] entry;
    int unsigned                 frame;
    bit                          found;
    res   = '0;
    found = 1'b0;
    if (int'(dir) < NUM_DIRS) begin
      if (cmd == pfa_pkg::CMD_ALLOC) begin
        if (frames_left != 0) begin
          for (int i = 0; i < FRAME_COUNT && !found; i++) begin
            if (!frame_busy[i]) begin
              frame_busy[i] = 1'b1;
              frames_left--;
              dir_table[dir][vpage] = {ENTRY_FRAME_W'(i), pfa_pkg::USER_FLAGS};
              res.ok    = 1'b1;
              res.frame = pfa_pkg::FRAME_OUT_W'(i);
              found     = 1'b1;
            end
          end
        end
      end else begin
        entry = dir_table[dir][vpage];
        frame = int'(entry[pfa_pkg::ENTRY_W-1:pfa_pkg::E_FRAME_LSB]);
        if (entry[pfa_pkg::E_PRESENT_BIT] && frame < FRAME_COUNT) begin
          // A frame that is already free keeps the count as it is.
          if (frame_busy[frame]) begin
            frame_busy[frame] = 1'b0;
            frames_left++;
          end
          dir_table[dir][vpage] = '0;
          res.ok    = 1'b1;
          res.frame = pfa_pkg::FRAME_OUT_W'(frame);
        end
      end
    end
    res.free_cnt = pfa_pkg::FREE_OUT_W'(frames_left);
    return res;
  endfunction

  // Drives one request word, waits for it to be taken and records what
  // the response should be.
  task automatic send_request(input logic cmd, input logic [pfa_pkg::DIR_SEL_W-1:0] dir,
                              input logic [pfa_pkg::VPAGE_W-1:0] vpage, input bit typed,
                              input result_t want);
    result_t res;
    req_valid <= 1'b1;
    req_cmd   <= cmd;
    req_dir   <= dir;
    req_vpage <= vpage;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    res = apply_request(cmd, dir, vpage);
    pending_results.push_back(typed ? want : res);
    if (cmd == pfa_pkg::CMD_ALLOC) begin
      if (res.ok) begin
        alloc_granted++;
        mapped_slots.push_back(slot_t'{dir, vpage});
      end else begin
        alloc_refused++;
      end
    end else if (res.ok) begin
      free_granted++;
    end else begin
      free_refused++;
    end
  endtask

  // Bursts of back-to-back words with random gaps in between, unless the sender is steady.
  task automatic pace_sender();
    if (sender_steady) begin
      burst_left = 0;
    end else if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 23);
    end
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [pfa_pkg::VPAGE_W-1:0] pick_vpage();
    if ($urandom_range(1)) begin
      return pfa_pkg::VPAGE_W'($urandom_range(pfa_pkg::DIR_ENTRIES - 1));
    end
    return HOT_PAGES[$urandom_range(7)];
  endfunction

  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_ALWAYS: begin
        rsp_ready <= 1'b1;
      end
      RX_RANDOM: begin
        rsp_ready <= ($urandom_range(99) >= 35);
      end
      default: begin
        rsp_ready <= ((rx_tick % 11) < 7);
      end
    endcase
  end

  always @(posedge clk_i) begin
    if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
        (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  result_t got_word;
  result_t want_word;

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got_word = '{rsp_if.ok, rsp_if.frame_index, rsp_if.frames_free};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("Unexpected response word: ok=%0d frame=%0d free=%0d",
                   got_word.ok, got_word.frame, got_word.free_cnt);
        end
      end else begin
        want_word = pending_results.pop_front();
        checked_words++;
        if (got_word.ok !== want_word.ok || got_word.frame !== want_word.frame ||
            got_word.free_cnt !== want_word.free_cnt) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("Word %0d: want ok=%0d frame=%0d free=%0d, got ok=%0d frame=%0d free=%0d",
                     checked_words, want_word.ok, want_word.frame, want_word.free_cnt,
                     got_word.ok, got_word.frame, got_word.free_cnt);
          end
        end
      end
    end
  end

  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("No word moved for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    logic                          cmd;
    logic [pfa_pkg::DIR_SEL_W-1:0] dir;
    logic [pfa_pkg::VPAGE_W-1:0]   vpage;
    int unsigned                   idx;

    reset_allocator();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int s = 0; s < STEP_N; s++) begin
      send_request(steps[s].cmd, pfa_pkg::DIR_SEL_W'(steps[s].dir),
                   pfa_pkg::VPAGE_W'(steps[s].vpage), steps[s].typed, steps[s].want);
      pace_sender();
    end

    // A directory index of NUM_DIRS or more, and a mapped frame beyond the
    // bitmap, cannot occur at this size: the field and the map both fit.
    for (int c = 0; c < CHUNK_N; c++) begin
      rx_mode       <= rx_mode_e'(c % 3);
      sender_steady = (c == 3);
      for (int n = 0; n < CHUNK_ITEMS; n++) begin
        cmd = ($urandom_range(99) < alloc_pct[c]) ? pfa_pkg::CMD_ALLOC : pfa_pkg::CMD_FREE;
        dir = pfa_pkg::DIR_SEL_W'($urandom_range((1 << pfa_pkg::DIR_SEL_W) - 1));
        vpage = pick_vpage();
        if (cmd == pfa_pkg::CMD_ALLOC) begin
          // Mostly map empty entries, so that frames are not lost to
          // overwritten entries.
          if ($urandom_range(99) < 92) begin
            for (int t = 0; t < 8 && dir_table[dir][vpage][pfa_pkg::E_PRESENT_BIT]; t++) begin
              dir   = pfa_pkg::DIR_SEL_W'($urandom_range((1 << pfa_pkg::DIR_SEL_W) - 1));
              vpage = pick_vpage();
            end
          end
        end else if (mapped_slots.size() != 0 && $urandom_range(99) < 85) begin
          idx   = $urandom_range(mapped_slots.size() - 1);
          dir   = mapped_slots[idx].dir;
          vpage = mapped_slots[idx].vpage;
          mapped_slots.delete(idx);
        end
        send_request(cmd, dir, vpage, 1'b0, '0);
        pace_sender();
      end
      if (c % 2 == 0) drain_responses();
    end

    drain_responses();
    repeat (20) @(posedge clk_i);

    $display("Allocations %0d granted, %0d refused; frees %0d granted, %0d refused",
             alloc_granted, alloc_refused, free_granted, free_refused);
    $display("Checked %0d response words, %0d mismatches", checked_words, mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
